### rtl/streaming_max_pool_defines.svh
// ----------------------------------------------------------------------------
// streaming_max_pool_defines
// assertion macros shared by the max pooling block
// ----------------------------------------------------------------------------
`ifndef STREAMING_MAX_POOL_DEFINES_SVH
`define STREAMING_MAX_POOL_DEFINES_SVH

// condition holds in the same cycle
`define SMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define SMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// shared types, constants and the small divider of the max pooling block
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_WINDOW   = 4;
  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_SAMPLE_BITS  = 8;

  localparam int MAX_HEIGHT = 64;

  localparam int CFG_DIM_BITS = 7;
  localparam int CFG_WIN_BITS = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_DIM_BITS-1:0] RST_MAP_WIDTH     = 7'd28;
  localparam logic [CFG_DIM_BITS-1:0] RST_MAP_HEIGHT    = 7'd28;
  localparam logic [CFG_DIM_BITS-1:0] RST_CHANNEL_COUNT = 7'd6;
  localparam logic [CFG_WIN_BITS-1:0] RST_WINDOW_SIZE   = 3'd2;

  // operand width of the window divider, covers positions up to 1024
  localparam int DIV_BITS    = 11;
  localparam int RECIP_SHIFT = 14;
  localparam int PROD_BITS   = DIV_BITS + RECIP_SHIFT;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAP_WIDTH,
    CFG_MAP_HEIGHT,
    CFG_CHANNEL_COUNT,
    CFG_WINDOW_SIZE
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DIM_BITS-1:0] map_width;
    logic [CFG_DIM_BITS-1:0] map_height;
    logic [CFG_DIM_BITS-1:0] channel_count;
    logic [CFG_WIN_BITS-1:0] window_size;
  } cfg_regs_t;

  // control of one request held between the scan stage and the merge stage
  typedef struct packed {
    logic valid;
    logic do_write;
    logic use_old;
    logic emit;
    logic done;
  } scan_req_t;

  // floor(x / k) for k in 1..8, reciprocal multiply exact for x below 2730
  function automatic logic [DIV_BITS-1:0] div_small(input logic [DIV_BITS-1:0] x,
                                                    input logic [3:0] k);
    logic [PROD_BITS-1:0] prod;
    logic [DIV_BITS-1:0]  q;
    prod = '0;
    case (k)
      4'd2:    q = x >> 1;
      4'd4:    q = x >> 2;
      4'd8:    q = x >> 3;
      4'd3: begin
        prod = PROD_BITS'(x) * PROD_BITS'(5462);
        q    = prod[RECIP_SHIFT +: DIV_BITS];
      end
      4'd5: begin
        prod = PROD_BITS'(x) * PROD_BITS'(3277);
        q    = prod[RECIP_SHIFT +: DIV_BITS];
      end
      4'd6: begin
        prod = PROD_BITS'(x) * PROD_BITS'(2731);
        q    = prod[RECIP_SHIFT +: DIV_BITS];
      end
      4'd7: begin
        prod = PROD_BITS'(x) * PROD_BITS'(2341);
        q    = prod[RECIP_SHIFT +: DIV_BITS];
      end
      default: q = x;
    endcase
    return q;
  endfunction

endpackage

### rtl/smp_row_buf.sv
// ----------------------------------------------------------------------------
// smp_row_buf
// row buffer of partial column maxima, one write and one registered read port
// ----------------------------------------------------------------------------
module smp_row_buf #(
  parameter int DEPTH = 32,
  parameter int DW    = 8,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // write in the same cycle to the same entry is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/smp_scan.sv
// ----------------------------------------------------------------------------
// smp_scan
// stream position tracking, horizontal maximum and row buffer read issue
// ----------------------------------------------------------------------------
module smp_scan import smp_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int AW           = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_regs_t                     cfg_i,
  input  logic                          take_i,
  input  logic                          adv_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  output scan_req_t                     req_o,
  output logic signed [SAMPLE_BITS-1:0] hm_o,
  output logic [AW-1:0]                 addr_o
);

  localparam int BUF_DEPTH = MAX_WIDTH / 2;
  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int CPW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KW  = $clog2(MAX_WINDOW + 1);
  localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RPW = $clog2(MAX_HEIGHT);
  localparam int CCW = $clog2(MAX_CHANNELS + 1);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [XW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [CCW-1:0] c_eff;
  logic [KW-1:0]  k_eff;
  logic [KW-1:0]  k_m1;

  logic [CPW-1:0] col_q, col_d;
  logic [RPW-1:0] row_q, row_d;
  logic [CHW-1:0] chan_q, chan_d;
  logic [PW-1:0]  cph_q, cph_d;
  logic [PW-1:0]  rph_q, rph_d;
  logic signed [SAMPLE_BITS-1:0] hm_q, hm_d;

  logic [DIV_BITS-1:0] oc_x, orow_x, out_w_x, out_h_x;
  logic [XW-1:0]  col_next;
  logic [HW-1:0]  row_next;
  logic [CCW-1:0] chan_next;
  logic col_end, row_end, in_win, win_end, rd_cond;
  scan_req_t req_d;

  scan_req_t s1_q;
  logic signed [SAMPLE_BITS-1:0] hm_s1_q;
  logic [AW-1:0] addr_s1_q;

  // register values clamped to their legal ranges
  always_comb begin
    if (cfg_i.map_width == '0) begin
      w_eff = XW'(1);
    end else if (32'(cfg_i.map_width) > 32'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(cfg_i.map_width);
    end
    if (cfg_i.map_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_i.map_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_i.map_height);
    end
    if (cfg_i.channel_count == '0) begin
      c_eff = CCW'(1);
    end else if (32'(cfg_i.channel_count) > 32'(MAX_CHANNELS)) begin
      c_eff = CCW'(MAX_CHANNELS);
    end else begin
      c_eff = CCW'(cfg_i.channel_count);
    end
    if (cfg_i.window_size == '0) begin
      k_eff = KW'(1);
    end else if (32'(cfg_i.window_size) > 32'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(cfg_i.window_size);
    end
    k_m1 = k_eff - KW'(1);
  end

  always_comb begin
    oc_x    = div_small(DIV_BITS'(col_q), 4'(k_eff));
    orow_x  = div_small(DIV_BITS'(row_q), 4'(k_eff));
    out_w_x = div_small(DIV_BITS'(w_eff), 4'(k_eff));
    out_h_x = div_small(DIV_BITS'(h_eff), 4'(k_eff));

    col_end = KW'(cph_q) >= k_m1;
    row_end = KW'(rph_q) >= k_m1;
    // col below out_w * k is the same as col / k below out_w
    in_win  = (oc_x < out_w_x) && (orow_x < out_h_x);
    win_end = in_win && col_end;
    rd_cond = win_end && (rph_q != '0) && (k_eff > KW'(1));

    hm_d = hm_q;
    if (in_win) begin
      if ((cph_q == '0) || (sample_i > hm_q)) begin
        hm_d = sample_i;
      end
    end

    req_d.valid    = 1'b1;
    req_d.do_write = win_end && (oc_x < DIV_BITS'(BUF_DEPTH));
    req_d.use_old  = (rph_q != '0) && (k_eff > KW'(1));
    req_d.emit     = win_end && row_end;
    req_d.done     = win_end && row_end &&
                     (CCW'(chan_q) >= (c_eff - CCW'(1))) &&
                     (orow_x == (out_h_x - DIV_BITS'(1))) &&
                     (oc_x == (out_w_x - DIV_BITS'(1)));

    col_next  = XW'(col_q) + XW'(1);
    row_next  = HW'(row_q) + HW'(1);
    chan_next = CCW'(chan_q) + CCW'(1);

    cph_d  = col_end ? '0 : (cph_q + PW'(1));
    rph_d  = rph_q;
    col_d  = CPW'(col_next);
    row_d  = row_q;
    chan_d = chan_q;
    if (col_next >= w_eff) begin
      col_d = '0;
      cph_d = '0;
      rph_d = row_end ? '0 : (rph_q + PW'(1));
      row_d = RPW'(row_next);
      if (row_next >= h_eff) begin
        row_d  = '0;
        rph_d  = '0;
        chan_d = (chan_next >= c_eff) ? '0 : CHW'(chan_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      hm_q   <= '0;
      s1_q   <= '0;
    end else begin
      if (take_i) begin
        col_q  <= col_d;
        row_q  <= row_d;
        chan_q <= chan_d;
        cph_q  <= cph_d;
        rph_q  <= rph_d;
        hm_q   <= hm_d;
        s1_q   <= req_d;
      end else if (adv_i) begin
        s1_q.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      hm_s1_q   <= hm_d;
      addr_s1_q <= AW'(oc_x);
    end
  end

  assign rd_en_o   = take_i && rd_cond;
  assign rd_addr_o = AW'(oc_x);
  assign req_o     = s1_q;
  assign hm_o      = hm_s1_q;
  assign addr_o    = addr_s1_q;

endmodule

### rtl/streaming_max_pool.sv
// ----------------------------------------------------------------------------
// streaming_max_pool
// 2-D max pooling over a raster-ordered stream of quantized samples
// ----------------------------------------------------------------------------
// Samples enter on the input channel (in_valid_i, in_stall_o, sample_i) in
// raster order, one channel plane after another. Each full window_size by
// window_size square with stride window_size gives one request on the output
// channel (out_valid_o, out_stall_i, pooled_value_o, map_done_o); map_done_o
// marks the last window of the last plane. Edge columns and rows that do not
// fill a window give nothing.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i.
// Throughput: one sample per cycle while in_stall_o is low. A sample is
// read-merged against the row buffer in the cycle after acceptance, and its
// result is registered in the output register when the merge stage moves on.
// The row buffer has one read and one write port, read at acceptance and
// written in the merge cycle, with forwarding when both hit the same entry.
// Reset sets the positions to the start of a map and the registers to
// 28 x 28, 6 planes, window 2; the row buffer is not cleared, the first row
// of each window writes its entries before they are read.
// While the output register is stalled the block still takes samples that
// yield no result; a sample that completes a window waits in the merge stage
// and holds in_stall_o high until the output register frees.
// ----------------------------------------------------------------------------
`include "streaming_max_pool_defines.svh"

module streaming_max_pool import smp_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_DIM_BITS-1:0]       cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] pooled_value_o,
  output logic                          map_done_o
);

  localparam int BUF_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  cfg_regs_t cfg_q;
  scan_req_t s1_req;
  logic signed [SAMPLE_BITS-1:0] s1_hm;
  logic [AW-1:0] s1_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] old_val, vm;
  logic s1_adv, take, wr_en;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] pooled_q;
  logic                          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width     <= RST_MAP_WIDTH;
      cfg_q.map_height    <= RST_MAP_HEIGHT;
      cfg_q.channel_count <= RST_CHANNEL_COUNT;
      cfg_q.window_size   <= RST_WINDOW_SIZE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAP_WIDTH:     cfg_q.map_width     <= cfg_data_i;
        CFG_MAP_HEIGHT:    cfg_q.map_height    <= cfg_data_i;
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i;
        CFG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_data_i[CFG_WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // merge stage moves on unless its result finds the output register blocked
  assign s1_adv     = !s1_req.valid || !s1_req.emit || !out_valid_q || !out_stall_i;
  assign in_stall_o = !s1_adv;
  assign take       = in_valid_i && s1_adv;

  smp_scan #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .AW           (AW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .adv_i     (s1_adv),
    .sample_i  (sample_i),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .req_o     (s1_req),
    .hm_o      (s1_hm),
    .addr_o    (s1_addr)
  );

  always_comb begin
    old_val = $signed(rd_data);
    vm      = s1_hm;
    if (s1_req.use_old && (old_val > s1_hm)) begin
      vm = old_val;
    end
  end

  assign wr_en = s1_req.valid && s1_adv && s1_req.do_write;

  smp_row_buf #(
    .DEPTH (BUF_DEPTH),
    .DW    (SAMPLE_BITS),
    .AW    (AW)
  ) u_row_buf (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr),
    .wr_data_i (vm),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_req.valid && s1_adv && s1_req.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_req.valid && s1_adv && s1_req.emit) begin
      pooled_q <= vm;
      done_q   <= s1_req.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = pooled_q;
  assign map_done_o     = done_q;

  `SMP_ASSERT_NEXT(a_take_fills_stage, take, s1_req.valid, "accepted request missing in merge stage")
  `SMP_ASSERT_NEXT(a_read_means_merge, rd_en, s1_req.valid && s1_req.use_old, "row buffer read without merge")
  `SMP_ASSERT_NOW(a_blocked_holds, s1_req.valid && s1_req.emit && out_valid_q && out_stall_i, in_stall_o && !wr_en, "blocked merge stage moved on")
  `SMP_ASSERT_NOW(a_done_on_result, s1_req.valid && s1_req.done, s1_req.emit, "map end flagged without a result")

endmodule

### test/tb_streaming_max_pool.sv
// ----------------------------------------------------------------------------
// tb_streaming_max_pool
// self-checking bench for the streaming max pooling block
// ----------------------------------------------------------------------------
// Feeds raster-ordered samples under many map shapes and window sizes,
// including register values that clamp, and predicts every pooled window and
// its end-of-map flag in a scoreboard that tracks the stream position. Both
// channels idle at random; configuration changes only at map boundaries
// (apart from one mid-map window change at the start of a window row).
// ----------------------------------------------------------------------------
module tb_streaming_max_pool import smp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = DEF_SAMPLE_BITS;
  localparam int ROW_BUF     = DEF_MAX_WIDTH / 2;
  localparam int DRAIN_WAIT  = 8;
  localparam int RAND_ITEMS  = 1250;
  localparam int CYCLE_LIMIT = 200000;

  class pool_scoreboard;
    typedef struct packed {
      logic signed [SW-1:0] value;
      logic                 done;
    } pooled_t;

    logic [CFG_DIM_BITS-1:0] map_width     = RST_MAP_WIDTH;
    logic [CFG_DIM_BITS-1:0] map_height    = RST_MAP_HEIGHT;
    logic [CFG_DIM_BITS-1:0] channel_count = RST_CHANNEL_COUNT;
    logic [CFG_WIN_BITS-1:0] window_size   = RST_WINDOW_SIZE;

    logic signed [SW-1:0] column_max [ROW_BUF];
    logic signed [SW-1:0] row_max = '0;
    int unsigned col_pos, row_pos, chan_pos, col_phase, row_phase;

    pooled_t     pending[$];
    int unsigned windows_predicted;
    int unsigned errors;

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DIM_BITS-1:0] data);
      case (idx)
        CFG_MAP_WIDTH:     map_width = data;
        CFG_MAP_HEIGHT:    map_height = data;
        CFG_CHANNEL_COUNT: channel_count = data;
        CFG_WINDOW_SIZE:   window_size = data[CFG_WIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit at_map_start();
      return col_pos == 0 && row_pos == 0 && chan_pos == 0;
    endfunction

    // one accepted sample: update the window state, queue a pooled value when it completes a window
    function void note_sample(logic signed [SW-1:0] s);
      int unsigned w, h, c, k, out_w, out_h, oc;
      logic signed [SW-1:0] vm;
      bit col_end, row_end, done;
      w = clamp(map_width, DEF_MAX_WIDTH);
      h = clamp(map_height, MAX_HEIGHT);
      c = clamp(channel_count, DEF_MAX_CHANNELS);
      k = clamp(window_size, DEF_MAX_WINDOW);
      out_w = w / k;
      out_h = h / k;
      col_end = col_phase >= k - 1;
      row_end = row_phase >= k - 1;
      if (col_pos < out_w * k && row_pos < out_h * k) begin
        oc = col_pos / k;
        if (col_phase == 0 || s > row_max) row_max = s;
        if (col_end) begin
          vm = row_max;
          if (row_phase != 0 && k > 1 && oc < ROW_BUF && column_max[oc] > vm)
            vm = column_max[oc];
          if (oc < ROW_BUF) column_max[oc] = vm;
          if (row_end) begin
            done = chan_pos >= c - 1 && row_pos / k == out_h - 1 && oc == out_w - 1;
            pending.push_back('{value: vm, done: done});
            windows_predicted++;
          end
        end
      end
      col_phase = col_end ? 0 : col_phase + 1;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        col_phase = 0;
        row_phase = row_end ? 0 : row_phase + 1;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          row_phase = 0;
          chan_pos++;
          if (chan_pos >= c) chan_pos = 0;
        end
      end
    endfunction

    function void check_result(logic signed [SW-1:0] value, logic done);
      pooled_t exp_win;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pooled value %0d done %0b", value, done);
        return;
      end
      exp_win = pending.pop_front();
      if (exp_win.value !== value || exp_win.done !== done) begin
        errors++;
        if (errors <= 10)
          $display("pooled mismatch: expected %0d done %0b, got %0d done %0b",
                   exp_win.value, exp_win.done, value, done);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DIM_BITS-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SW-1:0]    sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SW-1:0]    pooled_value;
  logic                    map_done;

  pool_scoreboard sb = new();
  int unsigned    items_sent;
  int unsigned    cycle_count;
  bit             calm;

  streaming_max_pool u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pooled_value_o (pooled_value),
    .map_done_o     (map_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(pooled_value, map_done);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_sample(logic signed [SW-1:0] s);
    calm = items_sent >= 500 && items_sent < 750;
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    items_sent++;
  endtask

  // lets the block run dry before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apply_config(logic [CFG_DIM_BITS-1:0] w, logic [CFG_DIM_BITS-1:0] h,
                              logic [CFG_DIM_BITS-1:0] c, logic [CFG_DIM_BITS-1:0] k);
    cfg_idx_e                idx [4];
    logic [CFG_DIM_BITS-1:0] val [4];
    idx = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_CHANNEL_COUNT, CFG_WINDOW_SIZE};
    val = '{w, h, c, k};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [SW-1:0]    edge_map [15];
    logic [CFG_DIM_BITS-1:0] w_raw, h_raw, c_raw, k_raw;
    int unsigned             kind, target, sent, phase_no;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // 5 x 3 map, window 2: right column and bottom row fall outside
    edge_map = '{-128, 127, -1, 0, 99,
                 -128, -128, -2, -3, 127,
                 127, 127, 127, 127, 127};
    apply_config(7'd5, 7'd3, 7'd1, 7'd2);
    foreach (edge_map[i]) push_sample(edge_map[i]);
    wait_idle();

    // window shrinks mid-map at the start of a window row
    apply_config(7'd2, 7'd4, 7'd1, 7'd2);
    repeat (4) push_sample(-128);
    wait_idle();
    apply_config(7'd2, 7'd4, 7'd1, 7'd1);
    push_sample(-1);
    push_sample(1);
    push_sample(64);
    push_sample(-65);
    wait_idle();

    phase_no = 0;
    while (items_sent < RAND_ITEMS || sb.windows_predicted < 48) begin
      kind  = (phase_no < 4) ? phase_no : $urandom_range(0, 9);
      k_raw = 7'($urandom_range(0, 7));
      case (phase_no)
        0: k_raw = 7'd7;
        1: k_raw = 7'd0;
        2: k_raw = 7'd1;
        3: k_raw = 7'd4;
        default: ;
      endcase
      // upper data bits are not part of the window register
      if ($urandom_range(0, 3) == 0) k_raw = k_raw | 7'($urandom_range(1, 15) << 3);
      case (kind)
        0: begin
          w_raw = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
          h_raw = 7'($urandom_range(1, 8));
          c_raw = 7'd1;
        end
        1: begin
          w_raw = 7'($urandom_range(1, 4));
          h_raw = $urandom_range(0, 1) ? 7'd64 : 7'd127;
          c_raw = 7'd1;
        end
        2: begin
          w_raw = 7'($urandom_range(1, 3));
          h_raw = 7'($urandom_range(1, 3));
          c_raw = $urandom_range(0, 1) ? 7'd64 : 7'd127;
        end
        3: begin
          w_raw = '0;
          h_raw = '0;
          c_raw = '0;
        end
        default: begin
          w_raw = 7'($urandom_range(1, 12));
          h_raw = 7'($urandom_range(1, 12));
          c_raw = 7'($urandom_range(1, 3));
        end
      endcase
      wait_idle();
      apply_config(w_raw, h_raw, c_raw, k_raw);
      target = $urandom_range(40, 160);
      sent = 0;
      // whole maps only, so the next write lands on a map boundary
      do begin
        push_sample(SW'($urandom_range(0, 255)));
        sent++;
      end while (sent < target || !sb.at_map_start());
      phase_no++;
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/smp_pkg.sv
rtl/smp_row_buf.sv
rtl/smp_scan.sv
rtl/streaming_max_pool.sv
test/tb_streaming_max_pool.sv
